### hdl/tdn_pkg.sv
// Package: shared types, widths and constants of the temporal denoise block.
package tdn_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [6:0] ThreshReset = 7'd16;
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDenoiseEnable   = 2'd0,
    CfgMotionThreshold = 2'd1
  } cfg_idx_e;

  // Live configuration seen by the datapath.
  typedef struct packed {
    logic       denoise_enable;
    logic [6:0] motion_threshold;
  } cfg_t;

  // Stage 1 result: current pixel, per-channel averages and distances.
  typedef struct packed {
    logic [15:0] cur;
    logic [4:0]  avg_r;
    logic [5:0]  avg_g;
    logic [4:0]  avg_b;
    logic [4:0]  dif_r;
    logic [5:0]  dif_g;
    logic [4:0]  dif_b;
    logic        last;
  } s1_t;

  // Stage 2 result: selected pixel and flags.
  typedef struct packed {
    logic [15:0] pixel;
    logic        motion;
    logic        last;
  } s2_t;

  // Stage 3 result: one output item.
  typedef struct packed {
    logic [15:0] filtered_pixel;
    logic [31:0] bgra_word;
    logic        motion_seen;
    logic        frame_end;
  } s3_t;

endpackage

### hdl/tdn_if.sv
// Interfaces: pixel input, result output and configuration write channels.
interface tdn_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] cur_pixel;
  logic [15:0] prev_pixel;
  logic        last_in_frame;

  modport source (output valid, cur_pixel, prev_pixel, last_in_frame, input ready);
  modport sink   (input valid, cur_pixel, prev_pixel, last_in_frame, output ready);
endinterface

interface tdn_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered_pixel;
  logic [31:0] bgra_word;
  logic        motion_seen;
  logic        frame_end;

  modport source (output valid, filtered_pixel, bgra_word, motion_seen, frame_end,
                  input ready);
  modport sink   (input valid, filtered_pixel, bgra_word, motion_seen, frame_end,
                  output ready);
endinterface

interface tdn_cfg_if import tdn_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/tdn_cfg_regs.sv
// Configuration registers: enable and motion threshold.
module tdn_cfg_regs import tdn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdn_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgDenoiseEnable:   cfg_d.denoise_enable   = cfg_i.data[0];
        CfgMotionThreshold: cfg_d.motion_threshold = cfg_i.data[6:0];
        default:            cfg_d = cfg_q;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.denoise_enable   <= 1'b0;
      cfg_q.motion_threshold <= ThreshReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/tdn_diff.sv
// Stage 1: channel split, absolute differences and floor averages.
module tdn_diff import tdn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] cur_i,
  input  logic [15:0] prev_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output s1_t         out_o
);

  logic valid_q;
  s1_t  data_q, data_d;
  logic [4:0] cr, pr, cb, pb;
  logic [5:0] cg, pg;
  logic [5:0] sum_r, sum_b;
  logic [6:0] sum_g;

  assign cr = cur_i[15:11];
  assign cg = cur_i[10:5];
  assign cb = cur_i[4:0];
  assign pr = prev_i[15:11];
  assign pg = prev_i[10:5];
  assign pb = prev_i[4:0];

  assign sum_r = {1'b0, cr} + {1'b0, pr};
  assign sum_g = {1'b0, cg} + {1'b0, pg};
  assign sum_b = {1'b0, cb} + {1'b0, pb};

  always_comb begin
    data_d.cur   = cur_i;
    data_d.avg_r = sum_r[5:1];
    data_d.avg_g = sum_g[6:1];
    data_d.avg_b = sum_b[5:1];
    data_d.dif_r = (cr > pr) ? (cr - pr) : (pr - cr);
    data_d.dif_g = (cg > pg) ? (cg - pg) : (pg - cg);
    data_d.dif_b = (cb > pb) ? (cb - pb) : (pb - cb);
    data_d.last  = last_i;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

### hdl/tdn_select.sv
// Stage 2: difference sum, threshold compare and pixel select.
module tdn_select import tdn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  s1_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output s2_t  out_o
);

  logic       valid_q;
  s2_t        data_q, data_d;
  logic [6:0] dif_sum;
  logic       is_static;

  // Sum tops out at 125, fits in 7 bits.
  assign dif_sum   = {2'b00, in_i.dif_r} + {1'b0, in_i.dif_g} + {2'b00, in_i.dif_b};
  assign is_static = cfg_i.denoise_enable && (dif_sum < cfg_i.motion_threshold);

  always_comb begin
    data_d.pixel  = is_static ? {in_i.avg_r, in_i.avg_g, in_i.avg_b} : in_i.cur;
    data_d.motion = !is_static;
    data_d.last   = in_i.last;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

### hdl/tdn_expand.sv
// Stage 3: RGB565 to 8-bit BGRA expansion, output register.
module tdn_expand import tdn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  s2_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output s3_t  out_o
);

  logic       valid_q;
  s3_t        data_q, data_d;
  logic [4:0] r5, b5;
  logic [5:0] g6;

  assign r5 = in_i.pixel[15:11];
  assign g6 = in_i.pixel[10:5];
  assign b5 = in_i.pixel[4:0];

  always_comb begin
    data_d.filtered_pixel = in_i.pixel;
    data_d.bgra_word      = {AlphaOpaque,
                             r5, r5[4:2],
                             g6, g6[5:4],
                             b5, b5[4:2]};
    data_d.motion_seen    = in_i.motion;
    data_d.frame_end      = in_i.last;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

### hdl/temporal_denoise_rgb565_to_bgra.sv
// Top level: motion adaptive temporal denoise with RGB565 to BGRA expansion.
//
// Usage
//   pix_i : one transfer per pixel, current RGB565 pixel, co-located pixel of
//           the previous frame (from an external frame store), end-of-frame flag.
//   res_o : one transfer per pixel: filtered RGB565, opaque BGRA word,
//           motion flag and the end-of-frame flag, in input order.
//   cfg_i : register writes (0 = denoise enable, 1 = motion threshold);
//           always ready, unmapped indexes are dropped. Write only while idle.
// Timing
//   Three register stages (diff, select, expand). A pixel passes through the
//   diff, select and expand registers in turn before it shows as a result;
//   throughput is one pixel per clock while res_o is ready.
// Reset
//   All stages empty, denoise off, threshold 16. No clearing pass needed.
// Backpressure
//   Each stage holds its item while the next one is full and stalled, so
//   empty stages keep filling: up to three items sit in the pipe behind a
//   stalled receiver, and nothing is dropped or repeated.
module temporal_denoise_rgb565_to_bgra import tdn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdn_pix_if.sink   pix_i,
  tdn_res_if.source res_o,
  tdn_cfg_if.sink   cfg_i
);

  cfg_t cfg;

  // Stage handshakes
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;

  tdn_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Stage 1: per-channel distance and average
  tdn_diff u_diff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .cur_i       (pix_i.cur_pixel),
    .prev_i      (pix_i.prev_pixel),
    .last_i      (pix_i.last_in_frame),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_o       (s1_data)
  );

  // Stage 2: threshold decision
  tdn_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_i        (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_o       (s2_data)
  );

  // Stage 3: bit-replicated expansion, doubles as the output register
  tdn_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_i        (s2_data),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_o       (s3_data)
  );

  assign res_o.filtered_pixel = s3_data.filtered_pixel;
  assign res_o.bgra_word      = s3_data.bgra_word;
  assign res_o.motion_seen    = s3_data.motion_seen;
  assign res_o.frame_end      = s3_data.frame_end;

  // An empty or draining output stage lets the whole pipe take a pixel.
  a_accept_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_o.valid || res_o.ready) |-> pix_i.ready)
    else $error("input stalled although output stage can move");

  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.bgra_word[31:24] == AlphaOpaque))
    else $error("alpha byte not opaque");

  a_bgra_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.bgra_word[23:19] == res_o.filtered_pixel[15:11]) &&
                     (res_o.bgra_word[15:10] == res_o.filtered_pixel[10:5]) &&
                     (res_o.bgra_word[7:3]   == res_o.filtered_pixel[4:0])))
    else $error("BGRA word disagrees with filtered pixel");

endmodule

### verif/tb_temporal_denoise_rgb565_to_bgra.sv
// Testbench for the RGB565 temporal denoise block with BGRA expansion.
`timescale 1ns / 100ps

module tb_temporal_denoise_rgb565_to_bgra;
  import tdn_pkg::*;

  // Register stages in the pipe.
  localparam int unsigned LatencyCycles = 3;
  // Indexes past the register list; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;
  localparam int unsigned IdlePct = 12;
  localparam int unsigned RandPixels = 1050;

  // Holds the live register copy, predicts each pixel and checks results in order.
  class denoise_scoreboard;
    bit          den_en;
    logic [6:0]  thresh;
    s3_t         expected_q[$];
    int unsigned n_err;
    int unsigned n_checked;
    int unsigned n_averaged;

    function new();
      den_en = 1'b0;
      thresh = ThreshReset;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (cfg_idx_e'(idx))
        CfgDenoiseEnable:   den_en = data[0];
        CfgMotionThreshold: thresh = data[6:0];
        default: ;
      endcase
    endfunction

    function int chan_dist(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function s3_t predict(logic [15:0] cur, logic [15:0] prev, logic last);
      logic [4:0]  cr, pr, cb, pb, r5, b5;
      logic [5:0]  cg, pg, g6;
      logic [15:0] px;
      int          dsum;
      s3_t         e;
      px = cur;
      e.motion_seen = 1'b1;
      if (den_en) begin
        {cr, cg, cb} = cur;
        {pr, pg, pb} = prev;
        dsum = chan_dist(cr, pr) + chan_dist(cg, pg) + chan_dist(cb, pb);
        if (dsum < int'(thresh)) begin
          r5 = 5'((int'(cr) + int'(pr)) >> 1);
          g6 = 6'((int'(cg) + int'(pg)) >> 1);
          b5 = 5'((int'(cb) + int'(pb)) >> 1);
          px = {r5, g6, b5};
          e.motion_seen = 1'b0;
        end
      end
      {r5, g6, b5} = px;
      e.filtered_pixel = px;
      e.bgra_word = {AlphaOpaque, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
      e.frame_end = last;
      return e;
    endfunction

    function void note_pixel(logic [15:0] cur, logic [15:0] prev, logic last);
      expected_q.push_back(predict(cur, prev, last));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      n_err++;
    endtask

    task check_result(s3_t got);
      s3_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (!e.motion_seen) n_averaged++;
      if (got.filtered_pixel !== e.filtered_pixel)
        report($sformatf("filtered_pixel %h, want %h", got.filtered_pixel, e.filtered_pixel));
      if (got.bgra_word !== e.bgra_word)
        report($sformatf("bgra_word %h, want %h", got.bgra_word, e.bgra_word));
      if (got.motion_seen !== e.motion_seen)
        report($sformatf("motion_seen %b, want %b", got.motion_seen, e.motion_seen));
      if (got.frame_end !== e.frame_end)
        report($sformatf("frame_end %b, want %b", got.frame_end, e.frame_end));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tdn_pix_if pix ();
  tdn_res_if res ();
  tdn_cfg_if cfg ();

  temporal_denoise_rgb565_to_bgra dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  denoise_scoreboard sb = new();

  // Idle switches per side; cleared for the no-idle stretch.
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned n_sent;
  int unsigned n_cfg;
  int unsigned frame_left;

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sink side: ready changes on the falling edge only.
  always @(negedge clk_i) begin
    res.ready <= !rx_idle_en || ($urandom_range(99) >= IdlePct);
  end

  // Result monitor: a transfer is valid && ready at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      sb.check_result('{res.filtered_pixel, res.bgra_word, res.motion_seen, res.frame_end});
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [15:0] pack565(logic [4:0] r, logic [5:0] g, logic [4:0] b);
    return {r, g, b};
  endfunction

  // One pixel transfer, with optional idle cycles ahead of it.
  task automatic send_pixel(logic [15:0] cur, logic [15:0] prev, logic last);
    while (tx_idle_en && $urandom_range(99) < IdlePct) begin
      @(negedge clk_i);
      pix.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix.valid         <= 1'b1;
    pix.cur_pixel     <= cur;
    pix.prev_pixel    <= prev;
    pix.last_in_frame <= last;
    do @(posedge clk_i); while (!pix.ready);
    sb.note_pixel(cur, prev, last);
    n_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Drain and let the pipe go fully quiet before touching registers.
  task automatic settle_pipe();
    drain_results();
    repeat (LatencyCycles + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    sb.set_reg(idx, data);
    n_cfg++;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Random pixel pair: mostly near-static neighbors so the sum lands around
  // the threshold, the rest fully random. Frames of random length.
  task automatic send_random_pixel();
    logic [15:0] cur, prev;
    logic [4:0]  r, b;
    logic [5:0]  g;
    int          span;
    logic        last;
    cur = 16'($urandom());
    if ($urandom_range(99) < 60) begin
      span = $urandom_range(0, 8);
      r = cur[15:11] + 5'($urandom_range(0, 2 * span) - span);
      g = cur[10:5]  + 6'($urandom_range(0, 2 * span) - span);
      b = cur[4:0]   + 5'($urandom_range(0, 2 * span) - span);
      prev = pack565(r, g, b);
    end else begin
      prev = 16'($urandom());
    end
    if (frame_left == 0) frame_left = $urandom_range(8, 40);
    frame_left--;
    last = (frame_left == 0);
    send_pixel(cur, prev, last);
  endtask

  initial begin
    int unsigned phase, plen, k;
    logic [CfgDataW-1:0] d;

    rst_ni            = 1'b0;
    pix.valid         = 1'b0;
    pix.cur_pixel     = '0;
    pix.prev_pixel    = '0;
    pix.last_in_frame = 1'b0;
    res.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = '0;
    cfg.data          = '0;
    frame_left        = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed part ---
    // Reset config: denoise off, pixels pass whatever the previous frame holds.
    send_pixel(16'h0000, 16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 1'b1);
    send_pixel(16'h1234, 16'h1235, 1'b0);

    // Enable with the reset threshold of 16.
    settle_pipe();
    write_reg(CfgDenoiseEnable, 8'h01);
    // sum 15: averaged; sum 16: not below threshold, passes
    send_pixel(pack565(5'd10, 6'd20, 5'd10), pack565(5'd15, 6'd25, 5'd15), 1'b0);
    send_pixel(pack565(5'd10, 6'd20, 5'd10), pack565(5'd15, 6'd25, 5'd16), 1'b0);
    // odd channel sums round down
    send_pixel(16'hFFFF, pack565(5'd30, 6'd62, 5'd30), 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'h0000, 16'h0000, 1'b1);

    // Zero threshold: nothing is static. Upper data bit must be ignored.
    settle_pipe();
    write_reg(CfgMotionThreshold, 8'h80);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'h0000, 16'h0001, 1'b1);

    // Max threshold: even the largest difference (125) averages.
    settle_pipe();
    write_reg(CfgMotionThreshold, 8'hFF);
    send_pixel(16'h0000, 16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 1'b1);

    // Threshold equal to the largest difference: passes.
    settle_pipe();
    write_reg(CfgMotionThreshold, 8'd125);
    send_pixel(16'h0000, 16'hFFFF, 1'b0);

    // Writes past the register list are dropped.
    settle_pipe();
    write_reg(CfgSpareA, 8'hFF);
    write_reg(CfgSpareB, 8'h00);
    send_pixel(16'h0000, 16'hFFFF, 1'b1);

    // Only bit 0 of the enable write counts.
    settle_pipe();
    write_reg(CfgDenoiseEnable, 8'hFE);
    send_pixel(16'h1234, 16'h1235, 1'b1);

    // --- random part: phases with fresh settings ---
    phase = 0;
    while (n_sent < RandPixels) begin
      settle_pipe();
      d = 8'($urandom());
      d[0] = ($urandom_range(99) < 75);
      write_reg(CfgDenoiseEnable, d);
      d = 8'($urandom());
      case ($urandom_range(5))
        0: d[6:0] = 7'd0;
        1: d[6:0] = 7'd127;
        default: ;
      endcase
      write_reg(CfgMotionThreshold, d);
      if ($urandom_range(9) == 0) write_reg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, 8'($urandom()));

      // Second phase runs flat out on both sides.
      tx_idle_en = (phase != 1);
      rx_idle_en = (phase != 1);
      plen = (phase == 1) ? 200 : $urandom_range(40, 160);
      for (k = 0; k < plen && n_sent < RandPixels; k++) begin
        // Sender holds off mid-phase until the pipe is empty.
        if (phase == 2 && k == plen / 2) drain_results();
        send_random_pixel();
      end
      phase++;
    end

    drain_results();
    repeat (LatencyCycles + 8) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.report("results still outstanding");

    $display("Ran %0d pixels over %0d setting phases, %0d register writes.",
             n_sent, phase, n_cfg);
    $display("Checked %0d results, %0d of them averaged as static.",
             sb.n_checked, sb.n_averaged);
    if (sb.n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
